@@ sv/prtb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package prtb_pkg;
    typedef enum logic [2:0] {
        KIND_SCHEDULED = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_FIRE      = 3'd3,
        KIND_TICK_DONE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        FUNC_SCHEDULE = 2'd0,
        FUNC_CANCEL   = 2'd1,
        FUNC_TICK     = 2'd2,
        FUNC_NONE     = 2'd3
    } t_func;

    localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
endpackage
`default_nettype wire

@@ sv/prtb_slot_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared per-slot tick update: saturating add, delay and period compares.
module prtb_slot_alu
    import prtb_pkg::*;
(
    input  wire logic        i_time_mode,
    input  wire logic        i_running,
    input  wire logic [31:0] i_accum,
    input  wire logic [31:0] i_delay,
    input  wire logic [31:0] i_period,
    input  wire logic [15:0] i_count,
    input  wire logic [15:0] i_repeat,
    input  wire logic        i_forever,
    input  wire logic [31:0] i_elapsed,
    output logic             o_running,
    output logic [31:0]      o_accum,
    output logic [15:0]      o_count,
    output logic             o_fired,
    output logic             o_final
);
    logic [32:0] sum;
    logic [31:0] acc;
    always_comb begin
        sum       = {1'b0, i_accum} + {1'b0, (i_time_mode ? i_elapsed : 32'd1)};
        acc       = sum[32] ? ACC_MAX : sum[31:0];
        o_running = i_running;
        if (!i_running && acc >= i_delay) begin
            o_running = 1'b1;
            acc       = '0;
        end
        o_fired = 1'b0;
        o_count = i_count;
        if (o_running && acc >= i_period) begin
            acc     = '0;
            o_fired = 1'b1;
            if (i_count != CNT_MAX) o_count = i_count + 16'd1;
        end
        o_final = o_fired && !i_forever && (o_count >= i_repeat);
        o_accum = acc;
    end
endmodule
`default_nettype wire

@@ sv/prioritized_repeating_timer_bank_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Prioritised repeating timer bank.
// Command channel: an item is taken when i_start is high and o_busy is low.
// func 0 schedules into the lowest free slot, 1 cancels a slot, 2 ticks the
// bank, 3 only answers tick done.
// Results appear on o_result_* for one cycle under o_strobe; the receiver
// cannot stall, so nothing is held back. o_last_of_run marks the last one.
// A schedule or cancel answer is registered through the S_CMD state, and
// the next item can be accepted on the same edge on which it is taken.
// A tick runs one shared update unit over every slot, one slot a cycle,
// then emits fires: each fire is found by a selection pass over the slots,
// one slot a cycle, followed by an emit state, and a last pass ends the run
// with tick done. o_busy stays high until a tick's last result is taken.
// Reset clears valid and running bits and the stamp counter; slot payload
// stores are left as they are.
module prioritized_repeating_timer_bank_top
    import prtb_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int PRIO_LEVELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_slot_id,
    input  wire logic        i_time_based,
    input  wire logic [31:0] i_delay_amount,
    input  wire logic [31:0] i_period_amount,
    input  wire logic [15:0] i_repeat_limit,
    input  wire logic        i_repeat_forever,
    input  wire logic [3:0]  i_task_priority,
    input  wire logic [31:0] i_elapsed_time,
    output logic             o_strobe,
    output logic [2:0]       o_result_kind,
    output logic [3:0]       o_result_slot,
    output logic             o_fire_final,
    output logic             o_last_of_run
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int PW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam logic [PW-1:0] PRIO_TOP = PW'(PRIO_LEVELS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CMD    = 5'b00010,
        S_UPDATE = 5'b00100,
        S_SELECT = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [NUM_SLOTS-1:0] r_valid, r_running, r_fired, r_final;
    logic [31:0] r_stamp_cnt;

    // slot stores, one index per cycle
    logic        r_mode   [NUM_SLOTS];
    logic [31:0] r_delay  [NUM_SLOTS];
    logic [31:0] r_period [NUM_SLOTS];
    logic [15:0] r_repeat [NUM_SLOTS];
    logic        r_forever[NUM_SLOTS];
    logic [15:0] r_count  [NUM_SLOTS];
    logic [31:0] r_accum  [NUM_SLOTS];
    logic [PW-1:0] r_prio [NUM_SLOTS];
    logic [31:0] r_stamp  [NUM_SLOTS];

    logic [31:0] r_elapsed;
    logic [CW-1:0] r_idx;
    logic        r_have_best;
    logic [SW-1:0] r_best;

    logic        r_strobe;
    t_kind       r_kind;
    logic [3:0]  r_rslot;
    logic        r_rfinal, r_rlast;

    logic [SW-1:0] idx;
    assign idx = r_idx[SW-1:0];

    logic alu_running, alu_fired, alu_final;
    logic [31:0] alu_accum;
    logic [15:0] alu_count;

    prtb_slot_alu u_alu (
        .i_time_mode(r_mode[idx]), .i_running(r_running[idx]),
        .i_accum(r_accum[idx]), .i_delay(r_delay[idx]),
        .i_period(r_period[idx]), .i_count(r_count[idx]),
        .i_repeat(r_repeat[idx]), .i_forever(r_forever[idx]),
        .i_elapsed(r_elapsed), .o_running(alu_running), .o_accum(alu_accum),
        .o_count(alu_count), .o_fired(alu_fired), .o_final(alu_final)
    );

    // lowest free slot
    logic          free_found;
    logic [SW-1:0] free_slot;
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    // candidate beats current best?
    logic beats;
    always_comb begin
        if (r_prio[idx] != r_prio[r_best]) beats = r_prio[idx] < r_prio[r_best];
        else if (r_stamp[idx] != r_stamp[r_best]) beats = r_stamp[idx] < r_stamp[r_best];
        else beats = idx < r_best;
    end

    logic last_idx;
    assign last_idx = (r_idx == CW'(NUM_SLOTS - 1));
    logic accept;
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = (i_func == FUNC_TICK) ? S_UPDATE : S_CMD;
            S_CMD:    n_state = S_IDLE;
            S_UPDATE: if (last_idx) n_state = S_SELECT;
            S_SELECT: if (last_idx) n_state = S_EMIT;
            S_EMIT:   n_state = (r_have_best) ? S_SELECT : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_running   <= '0;
            r_fired     <= '0;
            r_stamp_cnt <= '0;
            r_strobe    <= 1'b0;
            r_have_best <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state  <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    r_idx    <= '0;
                    if (accept) begin
                        r_elapsed <= i_elapsed_time;
                        r_fired   <= '0;
                        if (i_func == FUNC_SCHEDULE && free_found) begin
                            r_valid[free_slot]   <= 1'b1;
                            r_running[free_slot] <= 1'b0;
                            r_mode[free_slot]    <= i_time_based;
                            r_delay[free_slot]   <= i_delay_amount;
                            r_period[free_slot]  <= i_period_amount;
                            r_repeat[free_slot]  <= (i_repeat_limit == '0) ? 16'd1
                                                                            : i_repeat_limit;
                            r_forever[free_slot] <= i_repeat_forever;
                            r_count[free_slot]   <= '0;
                            r_accum[free_slot]   <= '0;
                            r_prio[free_slot]    <= ({28'd0, i_task_priority} >
                                                     32'(PRIO_LEVELS - 1))
                                                    ? PRIO_TOP : PW'(i_task_priority);
                            r_stamp[free_slot]   <= r_stamp_cnt;
                            r_stamp_cnt          <= r_stamp_cnt + 32'd1;
                        end
                        if (i_func == FUNC_CANCEL && {28'd0, i_slot_id} < 32'(NUM_SLOTS)) begin
                            r_valid[SW'(i_slot_id)]   <= 1'b0;
                            r_running[SW'(i_slot_id)] <= 1'b0;
                        end
                        r_kind   <= (i_func == FUNC_SCHEDULE)
                                    ? (free_found ? KIND_SCHEDULED : KIND_FULL)
                                    : (i_func == FUNC_CANCEL) ? KIND_CANCELLED
                                    : KIND_TICK_DONE;
                        r_rslot  <= (i_func == FUNC_SCHEDULE && free_found) ? 4'(free_slot)
                                    : (i_func == FUNC_CANCEL) ? i_slot_id : 4'd0;
                        r_rfinal <= 1'b0;
                        r_rlast  <= 1'b1;
                    end
                end
                S_CMD: r_strobe <= 1'b1;
                S_UPDATE: begin
                    r_strobe <= 1'b0;
                    if (r_valid[idx]) begin
                        r_running[idx] <= alu_running;
                        r_accum[idx]   <= alu_accum;
                        r_count[idx]   <= alu_count;
                        r_fired[idx]   <= alu_fired;
                        r_final[idx]   <= alu_final;
                    end
                    r_idx       <= last_idx ? '0 : r_idx + CW'(1);
                    r_have_best <= 1'b0;
                end
                S_SELECT: begin
                    r_strobe <= 1'b0;
                    if (r_fired[idx] && (!r_have_best || beats)) begin
                        r_have_best <= 1'b1;
                        r_best      <= idx;
                    end
                    r_idx <= last_idx ? '0 : r_idx + CW'(1);
                end
                S_EMIT: begin
                    r_strobe    <= 1'b1;
                    r_have_best <= 1'b0;
                    if (r_have_best) begin
                        r_kind   <= KIND_FIRE;
                        r_rslot  <= 4'(r_best);
                        r_rfinal <= r_final[r_best];
                        r_rlast  <= 1'b0;
                        r_fired[r_best] <= 1'b0;
                        if (r_final[r_best]) begin
                            r_valid[r_best]   <= 1'b0;
                            r_running[r_best] <= 1'b0;
                        end
                    end else begin
                        r_kind   <= KIND_TICK_DONE;
                        r_rslot  <= '0;
                        r_rfinal <= 1'b0;
                        r_rlast  <= 1'b1;
                    end
                end
                default: r_strobe <= 1'b0;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_result_slot = r_rslot;
    assign o_fire_final  = r_rfinal;
    assign o_last_of_run = r_rlast;

    // a fire is never the end of a run
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_FIRE) |-> !o_last_of_run)
        else $error("fire marked last");
    // an accepted command passes through S_CMD and answers with a last-of-run strobe
    a_cmd_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMD) |=> (o_strobe && o_last_of_run))
        else $error("command answer missing");
    // a run ending returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_run) |-> !o_busy)
        else $error("busy after last result");
endmodule
`default_nettype wire
